// ===== rtl/nearest_palette_color_assert.svh =====
// assertion macros used by the top-level rtl file
`ifndef NEAREST_PALETTE_COLOR_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define NPC_ASSERT_SAME(label, clk_i, rstn_i, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define NPC_ASSERT_NEXT(label, clk_i, rstn_i, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/npc_pkg.sv =====
// shared types and constants for the nearest palette color search
package npc_pkg;

  localparam int PALETTE_DEPTH_DEF = 32;
  localparam int CH_W = 8;
  localparam int SLOT_W = 5;
  localparam int CNT_W = 6;
  localparam int SQ_W = 2 * CH_W;
  localparam int DIST_W = 18;
  localparam int OUT_IDX_W = 5;
  localparam logic [CNT_W-1:0] ENTRIES_USED_RST = 6'd32;
  localparam logic [DIST_W-1:0] MAX_DIST = 18'd195075;

  typedef enum logic {
    MODE_LOAD   = 1'b0,
    MODE_LOOKUP = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [SLOT_W-1:0] slot;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
  } item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
  } best_t;

endpackage

// ===== rtl/nearest_palette_color.sv =====
// nearest palette color search, top level
//
// input channel in_*: one transaction per item. in_tuser is the mode:
// 0 loads palette slot entry_index with the color, 1 looks up the pixel.
// load transactions give no result; each lookup gives one result on out_*.
// config: cfg_wr_en with cfg_wr_data sets entries_used (reset 32); it is to be
// written by the user only while the block is idle; the block does not enforce this.
// the palette is a chain of PALETTE_DEPTH cells, one entry each. every item
// walks the chain two stages per cell, so loads and lookups stay in order.
// an accepted lookup passes both stage registers of every cell, then the output register.
// throughput: one item per cycle while out_tready is high.
// when the receiver stalls, the whole chain holds and in_tready drops
// unless the output register is empty.
// reset clears all valid state and sets entries_used to 32; palette entries
// stay undefined until loaded.
`include "nearest_palette_color_assert.svh"

module nearest_palette_color #(
  parameter int PALETTE_DEPTH = npc_pkg::PALETTE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // entry_index, pixel_red, pixel_green, pixel_blue, zero pad
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // best_index, best_red, best_green, best_blue, best_distance
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data
);

  localparam int IDX_W = $clog2(PALETTE_DEPTH);

  logic [npc_pkg::CNT_W-1:0] entries_used_r;
  logic                      adv;

  logic                 chain_vld  [0:PALETTE_DEPTH];
  npc_pkg::item_t       chain_item [0:PALETTE_DEPTH];
  npc_pkg::best_t       chain_best [0:PALETTE_DEPTH];
  logic [IDX_W-1:0]     chain_idx  [0:PALETTE_DEPTH];

  logic                          out_tvalid_r, out_tvalid_nxt;
  npc_pkg::best_t                out_best_r;
  logic [npc_pkg::OUT_IDX_W-1:0] out_idx_r;
  logic                          last_lookup;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_used_r <= npc_pkg::ENTRIES_USED_RST;
    end else if (cfg_wr_en) begin
      entries_used_r <= cfg_wr_data;
    end
  end

  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;

  always_comb begin
    chain_vld[0]        = in_tvalid;
    chain_item[0].mode  = npc_pkg::mode_t'(in_tuser);
    chain_item[0].slot  = in_tdata[4:0];
    chain_item[0].red   = in_tdata[12:5];
    chain_item[0].green = in_tdata[20:13];
    chain_item[0].blue  = in_tdata[28:21];
    chain_best[0]       = '0;
    chain_idx[0]        = '0;
  end

  for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
    npc_cell #(
      .CELL_ID (k),
      .IDX_W   (IDX_W)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .adv          (adv),
      .entries_used (entries_used_r),
      .in_vld       (chain_vld[k]),
      .in_item      (chain_item[k]),
      .in_best      (chain_best[k]),
      .in_idx       (chain_idx[k]),
      .out_vld      (chain_vld[k+1]),
      .out_item     (chain_item[k+1]),
      .out_best     (chain_best[k+1]),
      .out_idx      (chain_idx[k+1])
    );
  end

  assign last_lookup = chain_vld[PALETTE_DEPTH] &&
                       (chain_item[PALETTE_DEPTH].mode == npc_pkg::MODE_LOOKUP);

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (adv) begin
      out_tvalid_nxt = last_lookup;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && last_lookup) begin
      out_best_r <= chain_best[PALETTE_DEPTH];
      out_idx_r  <= npc_pkg::OUT_IDX_W'(chain_idx[PALETTE_DEPTH]);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_best_r.distance, out_best_r.blue, out_best_r.green,
                       out_best_r.red, out_idx_r};

  `NPC_ASSERT_SAME(a_rise_from_lookup, clk, rst_n, $rose(out_tvalid_r),
                   $past(last_lookup), "result without a lookup at the chain end")
  `NPC_ASSERT_SAME(a_dist_range, clk, rst_n, out_tvalid_r,
                   out_best_r.distance <= npc_pkg::MAX_DIST, "distance out of range")
  `NPC_ASSERT_NEXT(a_chain_holds, clk, rst_n, !adv,
                   $stable(chain_vld[PALETTE_DEPTH]), "chain moved during stall")

endmodule

// ===== rtl/npc_cell.sv =====
// one palette cell: holds one entry, squares the channel differences, then updates the best match
module npc_cell #(
  parameter int CELL_ID = 0,
  parameter int IDX_W   = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic [npc_pkg::CNT_W-1:0]    entries_used,
  input  logic                         in_vld,
  input  npc_pkg::item_t               in_item,
  input  npc_pkg::best_t               in_best,
  input  logic [IDX_W-1:0]             in_idx,
  output logic                         out_vld,
  output npc_pkg::item_t               out_item,
  output npc_pkg::best_t               out_best,
  output logic [IDX_W-1:0]             out_idx
);

  function automatic logic [npc_pkg::SQ_W-1:0] sq_diff(
    input logic [npc_pkg::CH_W-1:0] a,
    input logic [npc_pkg::CH_W-1:0] b
  );
    logic [npc_pkg::CH_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return npc_pkg::SQ_W'(d) * npc_pkg::SQ_W'(d);
  endfunction

  logic [npc_pkg::CH_W-1:0] ent_red_r, ent_green_r, ent_blue_r;
  logic                     wr_en;

  logic                     vld1_r;
  npc_pkg::item_t           item1_r;
  npc_pkg::best_t           best1_r;
  logic [IDX_W-1:0]         idx1_r;
  logic [npc_pkg::SQ_W-1:0] sq_red_r, sq_green_r, sq_blue_r;
  logic [npc_pkg::CH_W-1:0] e1_red_r, e1_green_r, e1_blue_r;

  logic                       vld2_r;
  npc_pkg::item_t             item2_r;
  npc_pkg::best_t             best2_r, best2_nxt;
  logic [IDX_W-1:0]           idx2_r, idx2_nxt;
  logic [npc_pkg::DIST_W-1:0] sum;
  logic                       active;
  logic                       take;

  assign wr_en = adv && in_vld && (in_item.mode == npc_pkg::MODE_LOAD) &&
                 (32'(in_item.slot) == CELL_ID);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_red_r   <= in_item.red;
      ent_green_r <= in_item.green;
      ent_blue_r  <= in_item.blue;
    end
  end

  // stage 1: squared channel differences
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item1_r    <= in_item;
      best1_r    <= in_best;
      idx1_r     <= in_idx;
      sq_red_r   <= sq_diff(in_item.red, ent_red_r);
      sq_green_r <= sq_diff(in_item.green, ent_green_r);
      sq_blue_r  <= sq_diff(in_item.blue, ent_blue_r);
      e1_red_r   <= ent_red_r;
      e1_green_r <= ent_green_r;
      e1_blue_r  <= ent_blue_r;
    end
  end

  // stage 2: sum and compare, strict less keeps the lower index on ties
  always_comb begin
    sum    = npc_pkg::DIST_W'(sq_red_r) + npc_pkg::DIST_W'(sq_green_r) +
             npc_pkg::DIST_W'(sq_blue_r);
    active = (CELL_ID == 0) || (32'(entries_used) > CELL_ID);
    take   = (item1_r.mode == npc_pkg::MODE_LOOKUP) && active &&
             ((CELL_ID == 0) || (sum < best1_r.distance));
    best2_nxt = best1_r;
    idx2_nxt  = idx1_r;
    if (take) begin
      best2_nxt.distance = sum;
      best2_nxt.red      = e1_red_r;
      best2_nxt.green    = e1_green_r;
      best2_nxt.blue     = e1_blue_r;
      idx2_nxt           = IDX_W'(CELL_ID);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (adv) begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item2_r <= item1_r;
      best2_r <= best2_nxt;
      idx2_r  <= idx2_nxt;
    end
  end

  assign out_vld  = vld2_r;
  assign out_item = item2_r;
  assign out_best = best2_r;
  assign out_idx  = idx2_r;

endmodule
